[rtl/core/stnl_pkg.sv]
`timescale 1ns / 1ps

package stnl_pkg;

	// Built slot count by default, and the capacity that reset selects.
	localparam int SLOTS_DEF = 16;
	localparam logic [4:0] CAP_RESET = 5'd10;

	// Field widths fixed by the interface.
	localparam int DATA_W = 32;
	localparam int CNT_W = 5;
	localparam int POS_W = 4;
	localparam int STAT_W = 2;

	// Request codes.
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROP = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADIDX = 2'd2;

	// Register index of the capacity register.
	localparam logic REG_CAPACITY = 1'b0;

	// One list entry.
	typedef struct packed {
		logic [DATA_W-1:0] score;
		logic [DATA_W-1:0] tag;
	} entry_t;

	// Values broadcast to every cell of the chain.
	typedef struct packed {
		logic [DATA_W-1:0] score;
		logic [DATA_W-1:0] tag;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] cap;
	} cmd_t;

	// Update strobes for the chain.
	typedef struct packed {
		logic add_we;
		logic rm_we;
	} ctl_t;

	// Per-cell flags seen by the top level.
	typedef struct packed {
		logic drop;
		logic hit;
	} flags_t;

endpackage

[rtl/core/sorted_top_n_list.sv]
`timescale 1ns / 1ps

// Sorted top-N list. The block keeps up to capacity (score, tag) entries in
// descending signed score order in a chain of compare-and-shift cells, one cell
// per slot. A request is taken whenever start is high; busy never rises, so a
// new request may follow in every cycle. Each request yields exactly one
// result, shown on the result ports with done high for one cycle, starting the
// cycle after the request was taken. All cells compare the new score and shift
// their neighbor's entry in the same cycle. The receiver cannot stall results,
// so it must take each one in the cycle that done marks. Capacity is to be
// written through the APB port at address 0 while no request is in flight; the
// user is bound to this, and the block itself does not enforce it.

module sorted_top_n_list import stnl_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Request channel.
	input  logic              start,
	output logic              busy,
	input  logic              opcode,
	input  logic [DATA_W-1:0] score,
	input  logic [DATA_W-1:0] tag,
	input  logic [POS_W-1:0]  position,
	// Result channel.
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [DATA_W-1:0] removed_score,
	output logic [DATA_W-1:0] removed_tag,
	output logic [CNT_W-1:0]  entry_count,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [CNT_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_eff;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] rm_score_q;
	logic [DATA_W-1:0] rm_tag_q;
	logic [CNT_W-1:0]  entry_count_q;

	cmd_t              cmd;
	ctl_t              ctl;
	entry_t            cell_data [SLOTS];
	logic [SLOTS-1:0]  cell_ge;
	flags_t            cell_flags [SLOTS];
	logic [SLOTS-1:0]  drop_vec;
	logic              full;
	logic              drop;
	logic              take_add;
	logic              take_rm;
	logic              rm_ok;
	entry_t            rm_entry;
	logic [CNT_W-1:0]  count_next;

	// The block finishes every request in the cycle it is taken.
	assign busy = 1'b0;

	// Configuration register. Only the word address bit selects the register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CNT_W){1'b0}}, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CNT_W-1:0];
		end
	end

	// A capacity of zero acts as one, and one above the built slot count as that count.
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(capacity_q) > SLOTS) begin
			cap_eff = CNT_W'(SLOTS);
		end else begin
			cap_eff = capacity_q;
		end
	end

	assign cmd = '{score: score, tag: tag, pos: position, count: count_q, cap: cap_eff};

	// The list counts as full once the count reaches the capacity, also when the
	// capacity was lowered below the count. A full list drops an add whose score
	// does not beat the entry in the last slot within the capacity.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			drop_vec[i] = cell_flags[i].drop;
		end
	end

	assign full = count_q >= cap_eff;
	assign drop = full && (|drop_vec);
	assign take_add = start && opcode == OP_ADD;
	assign take_rm = start && opcode == OP_REMOVE;
	assign rm_ok = {1'b0, position} < count_q;
	assign ctl.add_we = take_add && !drop;
	assign ctl.rm_we = take_rm && rm_ok;

	// Chain of cells. On an add each cell either keeps its entry, takes the new
	// one, or takes its upper neighbor's; on a remove cells at or below the index
	// take their lower neighbor's entry.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic   prev_ge;
		entry_t prev_data;
		entry_t next_data;

		if (i == 0) begin : g_first
			assign prev_ge = 1'b1;
			assign prev_data = '{score: score, tag: tag};
		end else begin : g_mid
			assign prev_ge = cell_ge[i-1];
			assign prev_data = cell_data[i-1];
		end

		if (i == SLOTS - 1) begin : g_last
			assign next_data = cell_data[i];
		end else begin : g_inner
			assign next_data = cell_data[i+1];
		end

		stnl_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.ctl      (ctl),
			.prev_ge  (prev_ge),
			.prev_data(prev_data),
			.next_data(next_data),
			.ge       (cell_ge[i]),
			.data     (cell_data[i]),
			.flags    (cell_flags[i])
		);
	end

	// The entry being removed is picked out of the one cell that matches the index.
	always_comb begin
		rm_entry = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (cell_flags[i].hit) begin
				rm_entry = rm_entry | cell_data[i];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (ctl.add_we) begin
			count_next = full ? cap_eff : count_q + CNT_W'(1);
		end else if (ctl.rm_we) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q <= start;
		end
	end

	// Result registers carry payload only.
	always_ff @(posedge clk) begin
		if (start) begin
			entry_count_q <= count_next;
			if (take_add) begin
				status_q <= drop ? ST_DROP : ST_DONE;
				rm_score_q <= '0;
				rm_tag_q <= '0;
			end else if (rm_ok) begin
				status_q <= ST_DONE;
				rm_score_q <= rm_entry.score;
				rm_tag_q <= rm_entry.tag;
			end else begin
				status_q <= ST_BADIDX;
				rm_score_q <= '0;
				rm_tag_q <= '0;
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign removed_score = rm_score_q;
	assign removed_tag = rm_tag_q;
	assign entry_count = entry_count_q;

	// Every request gives a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done)
		else $error("request without result");

	// The reported count matches the stored count right after the update.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> entry_count == count_q)
		else $error("reported count differs from stored count");

	// Only a successful remove returns a nonzero entry.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (removed_score == '0 && removed_tag == '0))
		else $error("nonzero entry on failed request");

	// The two top slots stay in descending order.
	a_sorted_top: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |->
			($signed(cell_data[0].score) >= $signed(cell_data[1].score)))
		else $error("list out of order");

endmodule

[rtl/core/stnl_cell.sv]
`timescale 1ns / 1ps

module stnl_cell import stnl_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic   clk,
	input  cmd_t   cmd,
	input  ctl_t   ctl,
	input  logic   prev_ge,
	input  entry_t prev_data,
	input  entry_t next_data,
	output logic   ge,
	output entry_t data,
	output flags_t flags
);

	entry_t data_q;
	logic   occupied;

	assign occupied = IDX < int'(cmd.count);
	// An occupied slot whose score is not below the new one stays in front of it.
	assign ge = occupied && ($signed(data_q.score) >= $signed(cmd.score));
	assign flags.drop = ge && (IDX == int'(cmd.cap) - 1);
	assign flags.hit = IDX == int'(cmd.pos);
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctl.add_we) begin
			if (!ge) begin
				if (prev_ge) begin
					data_q <= '{score: cmd.score, tag: cmd.tag};
				end else begin
					data_q <= prev_data;
				end
			end
		end else if (ctl.rm_we) begin
			if (IDX >= int'(cmd.pos)) begin
				data_q <= next_data;
			end
		end
	end

endmodule

[verif/stnl_list_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and configuration channels of the sorted list,
// keeps its own copy of the list and reports every result that differs.
module stnl_list_checker import stnl_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              opcode,
	input  logic [DATA_W-1:0] score,
	input  logic [DATA_W-1:0] tag,
	input  logic [POS_W-1:0]  position,
	input  logic              done,
	input  logic [STAT_W-1:0] status,
	input  logic [DATA_W-1:0] removed_score,
	input  logic [DATA_W-1:0] removed_tag,
	input  logic [CNT_W-1:0]  entry_count,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output int                fail_count,
	output int                pending_count
);

	localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] rm_score;
		logic [DATA_W-1:0] rm_tag;
		logic [CNT_W-1:0]  count;
	} list_result_t;

	logic signed [DATA_W-1:0] list_score [SLOTS];
	logic [DATA_W-1:0] list_tag [SLOTS];
	int held;
	logic [CNT_W-1:0] cap_reg;
	list_result_t expected_results [$];

	// Applies one request to the local list and returns the result it must give.
	function automatic list_result_t apply_list_request(logic op, logic signed [DATA_W-1:0] sc,
			logic [DATA_W-1:0] tg, logic [POS_W-1:0] pos);
		list_result_t r;
		int lim;
		int n;
		int i;
		bit keep;
		r = '0;
		r.status = ST_DONE;
		if (op == OP_ADD) begin
			lim = int'(cap_reg);
			if (lim == 0) lim = 1;
			if (lim > SLOTS) lim = SLOTS;
			n = held;
			keep = 1'b1;
			// A list at or above its capacity only takes a score above the last kept slot.
			if (n >= lim) begin
				if (sc <= list_score[lim-1]) begin
					keep = 1'b0;
					r.status = ST_DROP;
				end else begin
					n = lim;
				end
			end else begin
				n++;
			end
			if (keep) begin
				i = n - 1;
				while (i > 0 && sc > list_score[i-1]) begin
					list_score[i] = list_score[i-1];
					list_tag[i] = list_tag[i-1];
					i--;
				end
				list_score[i] = sc;
				list_tag[i] = tg;
				held = n;
			end
		end else if (int'(pos) >= held) begin
			r.status = ST_BADIDX;
		end else begin
			r.rm_score = list_score[pos];
			r.rm_tag = list_tag[pos];
			for (i = int'(pos) + 1; i < held; i++) begin
				list_score[i-1] = list_score[i];
				list_tag[i-1] = list_tag[i];
			end
			held--;
		end
		r.count = held[CNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count = fail_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			held = 0;
			cap_reg = CAP_RESET;
			fail_count = 0;
			expected_results.delete();
			pending_count <= 0;
		end else begin
			// The result of the previous request is compared before a new one is queued.
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no request pending: status %0d", status);
					fail_count = fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("removed_score", want.rm_score, removed_score);
					check_field("removed_tag", want.rm_tag, removed_tag);
					check_field("entry_count", DATA_W'(want.count), DATA_W'(entry_count));
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_list_request(opcode, score, tag, position));
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
				cap_reg = pwdata[CNT_W-1:0];
			pending_count <= expected_results.size();
		end
	end

endmodule

[verif/tb_sorted_top_n_list.sv]
`timescale 1ns / 1ps

// Testbench top for the sorted top-N list. This module only produces stimulus
// and gives the verdict; the checker beside the block predicts every result
// and counts mismatches.
module tb_sorted_top_n_list;
	import stnl_pkg::*;

	// Byte address of the capacity register on the configuration port.
	localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
	localparam int ITEMS_PER_PHASE = 72;
	// Far above the slowest expected run.
	localparam int CYCLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              opcode;
	logic [DATA_W-1:0] score;
	logic [DATA_W-1:0] tag;
	logic [POS_W-1:0]  position;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [DATA_W-1:0] removed_score;
	logic [DATA_W-1:0] removed_tag;
	logic [CNT_W-1:0]  entry_count;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int fail_count;
	int pending_count;
	// Percentage of cycles in which the sender holds back a request.
	int idle_pct;
	int cycle_count = 0;
	// Last list size reported by the block; only used to aim remove positions.
	logic [CNT_W-1:0] last_count;

	sorted_top_n_list dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .opcode(opcode), .score(score), .tag(tag),
		.position(position),
		.done(done), .status(status), .removed_score(removed_score),
		.removed_tag(removed_tag), .entry_count(entry_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	stnl_list_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .opcode(opcode), .score(score), .tag(tag),
		.position(position),
		.done(done), .status(status), .removed_score(removed_score),
		.removed_tag(removed_tag), .entry_count(entry_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count <= '0;
		end else if (done) begin
			last_count <= entry_count;
		end
	end

	// Presents one request and returns in the time step of the edge that took it.
	// With idling on, start drops for a random number of cycles first; start is
	// never lowered and raised in the same step, so back-to-back requests keep it
	// high across the boundary.
	task automatic push_request(input logic op, input logic [DATA_W-1:0] sc,
			input logic [DATA_W-1:0] tg, input logic [POS_W-1:0] pos);
		if ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
		end
		start <= 1'b1;
		opcode <= op;
		score <= sc;
		tag <= tg;
		position <= pos;
		do @(posedge clk); while (busy);
	endtask

	// Stops sending and waits for every outstanding result. Every request makes a
	// result, so a short tail is enough.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the upper data bits are noise the block
	// must ignore.
	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		logic [31:0] data;
		data = $urandom();
		data[CNT_W-1:0] = cap;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random request. Scores cluster in a narrow band to create ties, hit the
	// signed extremes now and then, and are otherwise fully random. Remove
	// positions mostly land inside the current list, sometimes anywhere.
	task automatic random_request();
		logic op;
		logic [DATA_W-1:0] sc;
		logic [POS_W-1:0] pos;
		int pick;
		op = ($urandom_range(99, 0) < 55) ? OP_ADD : OP_REMOVE;
		pick = $urandom_range(99, 0);
		if (pick < 40) begin
			sc = DATA_W'($urandom_range(6, 0)) - DATA_W'(3);
		end else if (pick < 55) begin
			case ($urandom_range(3, 0))
				0: sc = 32'h7FFF_FFFF;
				1: sc = 32'h8000_0000;
				2: sc = '0;
				default: sc = '1;
			endcase
		end else begin
			sc = $urandom();
		end
		if (last_count != 0 && $urandom_range(99, 0) < 80)
			pos = POS_W'($urandom_range(int'(last_count) - 1, 0));
		else
			pos = POS_W'($urandom_range(15, 0));
		push_request(op, sc, $urandom(), pos);
	endtask

	initial begin
		logic [CNT_W-1:0] phase_caps [7];
		int phase;
		arst_n = 1'b0;
		start <= 1'b0;
		opcode <= OP_ADD;
		score <= '0;
		tag <= '0;
		position <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity of ten, requests back to back.
		// Removes from an empty list must flag a bad index.
		push_request(OP_REMOVE, 32'h1234_5678, 32'h0, 4'd0);
		push_request(OP_REMOVE, 32'h0, 32'hFFFF_FFFF, 4'd15);
		// Signed extremes and ties: equal scores go behind the ones already held.
		push_request(OP_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd15);
		push_request(OP_ADD, 32'h8000_0000, 32'h0000_0000, 4'd0);
		push_request(OP_ADD, 32'h0000_0000, 32'h0000_00A1, 4'd5);
		push_request(OP_ADD, 32'h0000_0000, 32'h0000_00B2, 4'd10);
		push_request(OP_ADD, 32'h7FFF_FFFF, 32'h0000_00C3, 4'd0);
		push_request(OP_ADD, 32'hFFFF_FFFF, 32'h0000_00D4, 4'd0);
		// Remove from the middle, from the tail, and just past the tail.
		push_request(OP_REMOVE, 32'h0, 32'h0, 4'd1);
		push_request(OP_REMOVE, 32'h0, 32'h0, 4'd4);
		push_request(OP_REMOVE, 32'h0, 32'h0, 4'd4);
		// Fill the list up to its capacity.
		for (int i = 0; i < 6; i++)
			push_request(OP_ADD, DATA_W'(100 + i), DATA_W'(32'hE000_0000 + i), 4'd0);
		// Full list: equal to the last score is dropped, the minimum is dropped,
		// and a higher score pushes the last entry off the end.
		push_request(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0F01, 4'd3);
		push_request(OP_ADD, 32'h8000_0000, 32'h0000_0F02, 4'd3);
		push_request(OP_ADD, 32'h0000_0005, 32'h0000_0F03, 4'd3);
		drain_results();

		// Capacity cut below the list size: the list counts as full against slot
		// zero, a remove still works on the old entries, and the next kept add
		// trims the list to the new capacity.
		write_capacity(5'd1);
		push_request(OP_ADD, 32'h0000_0001, 32'h0000_0A01, 4'd0);
		push_request(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0A02, 4'd0);
		push_request(OP_REMOVE, 32'h0, 32'h0, 4'd0);
		push_request(OP_ADD, 32'h0000_00C8, 32'h0000_0A03, 4'd0);

		// Random phases. Capacities include zero and values above the slot count,
		// which act as one and as the full slot count. Sender idling rotates
		// through none, heavy and light.
		phase_caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, CNT_W'($urandom_range(15, 2)), 5'd10};
		for (phase = 0; phase < 7; phase++) begin
			drain_results();
			write_capacity(phase_caps[phase]);
			idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 83 : 6);
			repeat (ITEMS_PER_PHASE) random_request();
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
rtl/core/stnl_pkg.sv
rtl/core/stnl_cell.sv
rtl/core/sorted_top_n_list.sv
verif/stnl_list_checker.sv
verif/tb_sorted_top_n_list.sv
